// ----- rtl/core/rma_pkg.sv -----
// rma_pkg: shared widths, multiply-accumulate command type and small index helpers
// for the rotation matrix accumulator. No dependencies.
package rma_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int VAL_W         = 16;
    // multiplier b side: a 16-bit value or its exact negation
    localparam int BW            = 17;
    localparam int TAG_W         = 4;
    localparam int NUM_ELEM      = 9;
    // raw sum of three 16-bit squares
    localparam int NSQ_W         = 33;
    localparam int CFG_W         = 32;
    localparam int APB_AW        = 3;

    typedef enum logic [1:0] {
        DST_N,
        DST_M,
        DST_NSQ
    } dst_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             fin;
        dst_t             dst;
        logic [TAG_W-1:0] tag;
    } mac_cmd_t;

    // width of the multiplier a side: holds 1.0 + 2.0 at any fraction width
    function automatic int opa_w(input int frac);
        return ((frac > VAL_W) ? frac : VAL_W) + 2;
    endfunction

    function automatic int acc_w(input int frac);
        return opa_w(frac) + BW + 2;
    endfunction

    // row-major position of a 3x3 entry
    function automatic logic [TAG_W-1:0] idx3(input logic [1:0] hi, input logic [1:0] lo);
        return TAG_W'({hi, 1'b0}) + TAG_W'(hi) + TAG_W'(lo);
    endfunction

    function automatic logic signed [VAL_W-1:0] sel3(
        input logic [1:0]              i,
        input logic signed [VAL_W-1:0] x,
        input logic signed [VAL_W-1:0] y,
        input logic signed [VAL_W-1:0] z
    );
        logic signed [VAL_W-1:0] v;
        unique case (i)
            2'd0:    v = x;
            2'd1:    v = y;
            default: v = z;
        endcase
        return v;
    endfunction

    // negation with saturation to 16 bits
    function automatic logic signed [VAL_W-1:0] neg_sat(input logic signed [VAL_W-1:0] x);
        logic signed [VAL_W-1:0] v;
        if (x == {1'b1, {(VAL_W-1){1'b0}}})
        begin
            v = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else
        begin
            v = -x;
        end
        return v;
    endfunction

endpackage

// ----- rtl/core/rotation_matrix_accumulator.sv -----
// rotation_matrix_accumulator: top level with the configuration register and the
// sequenced matrix core. Depends on rma_pkg and rma_core.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+----------------------------------------
//   in       | in_valid / in_stall         | operation, cos_a, sin_a, cos_b, sin_b,
//            |                             | axis_x, axis_y, axis_z
//   out      | out_valid / out_stall       | element_value, element_index, last
//   config   | psel, penable, pwrite/pready| paddr, pwdata, prdata
//
// each item gives sixteen beats; one multiplier does one product term per cycle for a
// rotation (ops 0-2), the combined rotation and the axis-angle load, while a view
// load needs no products; the beats also wait on any output stall.
// in_stall is high from acceptance until the sixteenth beat is taken.
// reset leaves the orientation at identity and the norm threshold at 1.
module rotation_matrix_accumulator #(
    parameter int FRAC_BITS = rma_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rma_pkg::APB_AW-1:0]        paddr,
    input  logic [rma_pkg::CFG_W-1:0]         pwdata,
    output logic [rma_pkg::CFG_W-1:0]         prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        operation,
    input  logic signed [rma_pkg::VAL_W-1:0]  cos_a,
    input  logic signed [rma_pkg::VAL_W-1:0]  sin_a,
    input  logic signed [rma_pkg::VAL_W-1:0]  cos_b,
    input  logic signed [rma_pkg::VAL_W-1:0]  sin_b,
    input  logic signed [rma_pkg::VAL_W-1:0]  axis_x,
    input  logic signed [rma_pkg::VAL_W-1:0]  axis_y,
    input  logic signed [rma_pkg::VAL_W-1:0]  axis_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [rma_pkg::VAL_W-1:0]  element_value,
    output logic [3:0]                        element_index,
    output logic                              last
);
    import rma_pkg::*;

    logic [CFG_W-1:0] norm_min_reg;
    logic             cfg_wr;
    logic             reg_hit;

    assign pready  = 1'b1;
    // only addresses with the top address bit clear hold the register
    assign reg_hit = (paddr[APB_AW-1] == 1'b0);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = reg_hit ? norm_min_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_min_reg <= CFG_W'(1);
        end
        else if (cfg_wr && reg_hit)
        begin
            norm_min_reg <= pwdata;
        end
    end

    rma_core #(
        .FRAC_BITS(FRAC_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .axis_min_norm_sq (norm_min_reg),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .cos_a            (cos_a),
        .sin_a            (sin_a),
        .cos_b            (cos_b),
        .sin_b            (sin_b),
        .axis_x           (axis_x),
        .axis_y           (axis_y),
        .axis_z           (axis_z),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .element_value    (element_value),
        .element_index    (element_index),
        .last             (last)
    );

`ifndef NO_ASSERTIONS
    // no result beat is pending while a new item may enter
    a_idle_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("result beat pending while input is open");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after an accepted item");

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> element_index == 4'd15)
        else $error("last flagged away from the final element");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
            out_valid && element_index == $past(element_index) + 4'd1)
        else $error("element index did not advance after a beat");
`endif

endmodule

// ----- rtl/core/rma_mac.sv -----
// rma_mac: the shared multiply-accumulate unit, a registered product stage then an
// accumulate stage, with round half up and 16-bit saturation. Depends on rma_pkg.
module rma_mac #(
    parameter int  FRAC_BITS = rma_pkg::FRAC_BITS_DEF,
    localparam int AW        = rma_pkg::opa_w(FRAC_BITS),
    localparam int ACC_W     = rma_pkg::acc_w(FRAC_BITS)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rma_pkg::mac_cmd_t                 cmd,
    input  logic signed [AW-1:0]              a,
    input  logic signed [rma_pkg::BW-1:0]     b,
    output rma_pkg::mac_cmd_t                 res,
    output logic signed [ACC_W-1:0]           acc,
    output logic signed [rma_pkg::VAL_W-1:0]  rounded
);
    import rma_pkg::*;

    localparam int PW = AW + BW;
    localparam logic signed [ACC_W-1:0] HALF   = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    mac_cmd_t                cmd1_reg;
    mac_cmd_t                res_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [ACC_W-1:0] rnd_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd1_reg <= '0;
            res_reg  <= '0;
        end
        else
        begin
            cmd1_reg       <= cmd;
            res_reg        <= cmd1_reg;
            res_reg.valid  <= cmd1_reg.valid && cmd1_reg.last;
        end
    end

    always_comb
    begin
        acc_next = (cmd1_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(a) * PW'(b);
        if (cmd1_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // floor after adding half an lsb, then clamp
    always_comb
    begin
        rnd_sum = acc_reg + HALF;
        rnd_q   = rnd_sum >>> FRAC_BITS;
        if (rnd_q > SAT_HI)
        begin
            rounded = SAT_HI[VAL_W-1:0];
        end
        else if (rnd_q < SAT_LO)
        begin
            rounded = SAT_LO[VAL_W-1:0];
        end
        else
        begin
            rounded = rnd_q[VAL_W-1:0];
        end
    end

    assign res = res_reg;
    assign acc = acc_reg;

endmodule

// ----- rtl/core/rma_core.sv -----
// rma_core: sequencer, orientation and scratch registers and result beat stage; every
// product goes through one shared rma_mac. Depends on rma_pkg and rma_mac.
module rma_core #(
    parameter int FRAC_BITS = rma_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [rma_pkg::CFG_W-1:0]         axis_min_norm_sq,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        operation,
    input  logic signed [rma_pkg::VAL_W-1:0]  cos_a,
    input  logic signed [rma_pkg::VAL_W-1:0]  sin_a,
    input  logic signed [rma_pkg::VAL_W-1:0]  cos_b,
    input  logic signed [rma_pkg::VAL_W-1:0]  sin_b,
    input  logic signed [rma_pkg::VAL_W-1:0]  axis_x,
    input  logic signed [rma_pkg::VAL_W-1:0]  axis_y,
    input  logic signed [rma_pkg::VAL_W-1:0]  axis_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [rma_pkg::VAL_W-1:0]  element_value,
    output logic [3:0]                        element_index,
    output logic                              last
);
    import rma_pkg::*;

    localparam int AW    = opa_w(FRAC_BITS);
    localparam int ACC_W = acc_w(FRAC_BITS);
    localparam logic signed [AW-1:0]    ONE_A = {{(AW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [VAL_W-1:0] ONE16 =
        (FRAC_BITS >= 15) ? {1'b0, {(VAL_W-1){1'b1}}} : VAL_W'(1 << FRAC_BITS);

    typedef enum logic [2:0] {
        OP_ROT_X,
        OP_ROT_Y,
        OP_ROT_Z,
        OP_ROT_XY,
        OP_VIEW_XY,
        OP_VIEW_XZ,
        OP_VIEW_YZ,
        OP_AXIS
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_PRE_W,
        S_NORM,
        S_PROD,
        S_PROD_W,
        S_MUL,
        S_AXIS,
        S_CALC_W,
        S_COPY,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [1:0]              r_reg;
    logic [1:0]              c_reg;
    logic [1:0]              t_reg;
    logic [4:0]              cnt_reg;
    logic signed [VAL_W-1:0] ori_reg [NUM_ELEM];
    logic signed [VAL_W-1:0] m_reg [NUM_ELEM];
    logic signed [AW-1:0]    n_reg [NUM_ELEM];
    logic [NSQ_W-1:0]        nsq_reg;
    logic signed [VAL_W-1:0] ca_reg;
    logic signed [VAL_W-1:0] sa_reg;
    logic signed [VAL_W-1:0] cb_reg;
    logic signed [VAL_W-1:0] sb_reg;
    logic signed [VAL_W-1:0] ax_x_reg;
    logic signed [VAL_W-1:0] ax_y_reg;
    logic signed [VAL_W-1:0] ax_z_reg;
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic [3:0]              out_index_reg;
    logic                    out_last_reg;

    op_t                     op;
    logic                    in_fire;
    logic                    t_end;
    logic                    c_end;
    logic                    r_end;
    logic [TAG_W-1:0]        rc_idx;
    logic [TAG_W-1:0]        n_idx;
    logic [TAG_W-1:0]        o_idx;
    logic [TAG_W-1:0]        e_idx;
    logic [1:0]              erow;
    logic [1:0]              ecol;
    logic                    e_in;
    logic signed [AW-1:0]    n_val;
    logic signed [VAL_W-1:0] o_val;
    logic signed [VAL_W-1:0] emit_val;
    logic signed [AW-1:0]    skew;
    logic                    res_fin;

    mac_cmd_t                cmd;
    mac_cmd_t                res;
    logic signed [AW-1:0]    mac_a;
    logic signed [BW-1:0]    mac_b;
    logic signed [ACC_W-1:0] mac_acc;
    logic signed [VAL_W-1:0] mac_rnd;

    rma_mac #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .a       (mac_a),
        .b       (mac_b),
        .res     (res),
        .acc     (mac_acc),
        .rounded (mac_rnd)
    );

    assign op       = op_t'(operation);
    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && (state_reg == S_IDLE);
    assign t_end    = (t_reg == 2'd2);
    assign c_end    = (c_reg == 2'd2);
    assign r_end    = (r_reg == 2'd2);
    assign res_fin  = res.valid && res.fin;

    // one read port each on the scratch and orientation registers
    always_comb
    begin
        erow   = cnt_reg[1:0];
        ecol   = cnt_reg[3:2];
        e_in   = (erow != 2'd3) && (ecol != 2'd3);
        e_idx  = e_in ? idx3(erow, ecol) : '0;
        rc_idx = idx3(r_reg, c_reg);
        n_idx  = (state_reg == S_MUL) ? idx3(r_reg, t_reg) : rc_idx;
        o_idx  = (state_reg == S_EMIT) ? e_idx : idx3(t_reg, c_reg);
        n_val  = n_reg[n_idx];
        o_val  = ori_reg[o_idx];
        if (e_in)
        begin
            emit_val = o_val;
        end
        else if ((erow == 2'd3) && (ecol == 2'd3))
        begin
            emit_val = ONE16;
        end
        else
        begin
            emit_val = '0;
        end
    end

    // cross-product matrix of the axis
    always_comb
    begin
        unique case ({r_reg, c_reg})
            4'b0001: skew = -AW'(ax_z_reg);
            4'b0010: skew =  AW'(ax_y_reg);
            4'b0100: skew =  AW'(ax_z_reg);
            4'b0110: skew = -AW'(ax_x_reg);
            4'b1000: skew = -AW'(ax_y_reg);
            4'b1001: skew =  AW'(ax_x_reg);
            default: skew = '0;
        endcase
    end

    // operand and command issue, one product term per cycle
    always_comb
    begin
        cmd   = '0;
        mac_a = '0;
        mac_b = '0;
        unique case (state_reg)
            S_PRE:
            begin
                cmd.valid = 1'b1;
                cmd.first = 1'b1;
                cmd.last  = 1'b1;
                cmd.fin   = (cnt_reg[1:0] == 2'd3);
                cmd.dst   = DST_N;
                unique case (cnt_reg[1:0])
                    2'd0:
                    begin
                        mac_a   = AW'(sb_reg);
                        mac_b   = BW'(sa_reg);
                        cmd.tag = 4'd1;
                    end
                    2'd1:
                    begin
                        mac_a   = AW'(sb_reg);
                        mac_b   = BW'(ca_reg);
                        cmd.tag = 4'd2;
                    end
                    2'd2:
                    begin
                        mac_a   = AW'(cb_reg);
                        mac_b   = BW'(sa_reg);
                        cmd.tag = 4'd7;
                    end
                    default:
                    begin
                        mac_a   = AW'(cb_reg);
                        mac_b   = BW'(ca_reg);
                        cmd.tag = 4'd8;
                    end
                endcase
            end
            S_NORM:
            begin
                cmd.valid = 1'b1;
                cmd.first = (t_reg == 2'd0);
                cmd.last  = t_end;
                cmd.dst   = DST_NSQ;
                mac_a     = AW'(sel3(t_reg, ax_x_reg, ax_y_reg, ax_z_reg));
                mac_b     = BW'(sel3(t_reg, ax_x_reg, ax_y_reg, ax_z_reg));
            end
            S_PROD:
            begin
                cmd.valid = 1'b1;
                cmd.first = 1'b1;
                cmd.last  = 1'b1;
                cmd.fin   = r_end && c_end;
                cmd.dst   = DST_N;
                cmd.tag   = rc_idx;
                mac_a     = AW'(sel3(r_reg, ax_x_reg, ax_y_reg, ax_z_reg));
                mac_b     = BW'(sel3(c_reg, ax_x_reg, ax_y_reg, ax_z_reg));
            end
            S_MUL:
            begin
                cmd.valid = 1'b1;
                cmd.first = (t_reg == 2'd0);
                cmd.last  = t_end;
                cmd.fin   = r_end && c_end && t_end;
                cmd.dst   = DST_M;
                cmd.tag   = rc_idx;
                mac_a     = n_val;
                mac_b     = BW'(o_val);
            end
            S_AXIS:
            begin
                cmd.valid = 1'b1;
                cmd.first = (t_reg == 2'd0);
                cmd.last  = t_end;
                cmd.fin   = r_end && c_end && t_end;
                cmd.dst   = DST_M;
                cmd.tag   = rc_idx;
                unique case (t_reg)
                    2'd0:
                    begin
                        mac_a = ONE_A - AW'(ca_reg);
                        mac_b = BW'(signed'(n_val[VAL_W-1:0]));
                    end
                    2'd1:
                    begin
                        mac_a = skew;
                        mac_b = BW'(sa_reg);
                    end
                    default:
                    begin
                        mac_a = (r_reg == c_reg) ? ONE_A : '0;
                        mac_b = BW'(ca_reg);
                    end
                endcase
            end
            default:
            begin
                cmd.valid = 1'b0;
            end
        endcase
    end

    // sequencer, orientation and result beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            t_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_index_reg <= '0;
            out_last_reg  <= 1'b0;
            for (int k = 0; k < NUM_ELEM; k++)
            begin
                ori_reg[k] <= '0;
            end
            ori_reg[0] <= ONE16;
            ori_reg[4] <= ONE16;
            ori_reg[8] <= ONE16;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        r_reg   <= '0;
                        c_reg   <= '0;
                        t_reg   <= '0;
                        cnt_reg <= '0;
                        unique case (op)
                            OP_ROT_X, OP_ROT_Y, OP_ROT_Z:
                            begin
                                state_reg <= S_MUL;
                            end
                            OP_ROT_XY:
                            begin
                                state_reg <= S_PRE;
                            end
                            OP_AXIS:
                            begin
                                state_reg <= S_NORM;
                            end
                            OP_VIEW_XY:
                            begin
                                for (int k = 0; k < NUM_ELEM; k++)
                                begin
                                    ori_reg[k] <= '0;
                                end
                                ori_reg[0] <= ONE16;
                                ori_reg[4] <= ONE16;
                                ori_reg[8] <= ONE16;
                                state_reg  <= S_EMIT;
                            end
                            OP_VIEW_XZ:
                            begin
                                for (int k = 0; k < NUM_ELEM; k++)
                                begin
                                    ori_reg[k] <= '0;
                                end
                                ori_reg[0] <= ONE16;
                                ori_reg[5] <= ONE16;
                                ori_reg[7] <= -ONE16;
                                state_reg  <= S_EMIT;
                            end
                            OP_VIEW_YZ:
                            begin
                                for (int k = 0; k < NUM_ELEM; k++)
                                begin
                                    ori_reg[k] <= '0;
                                end
                                ori_reg[2] <= -ONE16;
                                ori_reg[4] <= ONE16;
                                ori_reg[6] <= ONE16;
                                state_reg  <= S_EMIT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PRE:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        state_reg <= S_PRE_W;
                    end
                end
                S_PRE_W:
                begin
                    if (res_fin)
                    begin
                        r_reg     <= '0;
                        c_reg     <= '0;
                        t_reg     <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_NORM:
                begin
                    if (t_end)
                    begin
                        t_reg     <= '0;
                        r_reg     <= '0;
                        c_reg     <= '0;
                        state_reg <= S_PROD;
                    end
                    else
                    begin
                        t_reg <= t_reg + 2'd1;
                    end
                end
                S_PROD:
                begin
                    if (!c_end)
                    begin
                        c_reg <= c_reg + 2'd1;
                    end
                    else
                    begin
                        c_reg <= '0;
                        if (!r_end)
                        begin
                            r_reg <= r_reg + 2'd1;
                        end
                        else
                        begin
                            r_reg     <= '0;
                            state_reg <= S_PROD_W;
                        end
                    end
                end
                S_PROD_W:
                begin
                    if (res_fin)
                    begin
                        cnt_reg <= '0;
                        if (nsq_reg > {1'b0, axis_min_norm_sq})
                        begin
                            r_reg     <= '0;
                            c_reg     <= '0;
                            t_reg     <= '0;
                            state_reg <= S_AXIS;
                        end
                        else
                        begin
                            // short axis falls back to identity
                            for (int k = 0; k < NUM_ELEM; k++)
                            begin
                                ori_reg[k] <= '0;
                            end
                            ori_reg[0] <= ONE16;
                            ori_reg[4] <= ONE16;
                            ori_reg[8] <= ONE16;
                            state_reg  <= S_EMIT;
                        end
                    end
                end
                S_MUL, S_AXIS:
                begin
                    if (!t_end)
                    begin
                        t_reg <= t_reg + 2'd1;
                    end
                    else
                    begin
                        t_reg <= '0;
                        if (!c_end)
                        begin
                            c_reg <= c_reg + 2'd1;
                        end
                        else
                        begin
                            c_reg <= '0;
                            if (!r_end)
                            begin
                                r_reg <= r_reg + 2'd1;
                            end
                            else
                            begin
                                r_reg     <= '0;
                                state_reg <= S_CALC_W;
                            end
                        end
                    end
                end
                S_CALC_W:
                begin
                    // last element lands in the scratch on this edge
                    if (res_fin)
                    begin
                        state_reg <= S_COPY;
                    end
                end
                S_COPY:
                begin
                    for (int k = 0; k < NUM_ELEM; k++)
                    begin
                        ori_reg[k] <= m_reg[k];
                    end
                    cnt_reg   <= '0;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        if (!cnt_reg[4])
                        begin
                            out_valid_reg <= 1'b1;
                            out_value_reg <= emit_val;
                            out_index_reg <= cnt_reg[3:0];
                            out_last_reg  <= &cnt_reg[3:0];
                            cnt_reg       <= cnt_reg + 5'd1;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // operands, rotation entries and unit results
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ca_reg   <= cos_a;
            sa_reg   <= sin_a;
            cb_reg   <= cos_b;
            sb_reg   <= sin_b;
            ax_x_reg <= axis_x;
            ax_y_reg <= axis_y;
            ax_z_reg <= axis_z;
            unique case (op)
                OP_ROT_X:
                begin
                    n_reg[0] <= ONE_A;       n_reg[1] <= '0;           n_reg[2] <= '0;
                    n_reg[3] <= '0;          n_reg[4] <= AW'(cos_a);   n_reg[5] <= -AW'(sin_a);
                    n_reg[6] <= '0;          n_reg[7] <= AW'(sin_a);   n_reg[8] <= AW'(cos_a);
                end
                OP_ROT_Y:
                begin
                    n_reg[0] <= AW'(cos_a);  n_reg[1] <= '0;           n_reg[2] <= AW'(sin_a);
                    n_reg[3] <= '0;          n_reg[4] <= ONE_A;        n_reg[5] <= '0;
                    n_reg[6] <= -AW'(sin_a); n_reg[7] <= '0;           n_reg[8] <= AW'(cos_a);
                end
                OP_ROT_Z:
                begin
                    n_reg[0] <= AW'(cos_a);  n_reg[1] <= -AW'(sin_a);  n_reg[2] <= '0;
                    n_reg[3] <= AW'(sin_a);  n_reg[4] <= AW'(cos_a);   n_reg[5] <= '0;
                    n_reg[6] <= '0;          n_reg[7] <= '0;           n_reg[8] <= ONE_A;
                end
                OP_ROT_XY:
                begin
                    // the four cross terms come from the unit
                    n_reg[0] <= AW'(cos_b);
                    n_reg[3] <= '0;
                    n_reg[4] <= AW'(cos_a);
                    n_reg[5] <= AW'(neg_sat(sin_a));
                    n_reg[6] <= AW'(neg_sat(sin_b));
                end
                default:
                begin
                end
            endcase
        end
        if (res.valid)
        begin
            unique case (res.dst)
                DST_N:   n_reg[res.tag] <= AW'(mac_rnd);
                DST_M:   m_reg[res.tag] <= mac_rnd;
                DST_NSQ: nsq_reg <= mac_acc[NSQ_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign element_value = out_value_reg;
    assign element_index = out_index_reg;
    assign last          = out_last_reg;

endmodule
